@@ rtl/tpmq_pkg.sv @@
// shared types and constants for the tree path max-edge query engine
// no dependencies; imported by the top, the sequencer and the checker

package tpmq_pkg;

    // node index and depth storage
    localparam int NODE_COUNT = 1024;
    localparam int NODE_BITS  = 10;
    localparam int DEPTH_BITS = 11;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = 11'h7ff;
    localparam logic [DEPTH_BITS-1:0] DEPTH_ROOT = 11'h001;

    // stream beat layout
    localparam int WEIGHT_IN_BITS = 32;
    localparam int RESULT_BITS    = 32;
    localparam int NODE_LSB       = 0;
    localparam int OTHER_LSB      = 10;
    localparam int WEIGHT_LSB     = 20;
    localparam int S_TDATA_BITS   = 56;
    localparam int M_TDATA_BITS   = 32;

    typedef enum logic
    {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_A_ROOT,
        ST_A_DEP,
        ST_A_RD,
        ST_A_WR,
        ST_Q_DEP,
        ST_Q1_ANC,
        ST_Q1_DEP,
        ST_Q2_CHK,
        ST_Q_FIN,
        ST_Q_OUT
    } state_t;

endpackage

@@ rtl/tree_path_max_edge_query.sv @@
// add: a root node writes its own row at every jump level; any other node writes level 0,
// then reads and writes each higher level in turn; query: the climb to equal depth
// reads a lifting row, then a depth, at each level, and the common climb reads both
// endpoints at each level on the two read ports of the lifting ram
// reset clears the sequencer and the output register only; table contents are kept,
// so a node has to be added before it is used as a parent or a query endpoint

module tree_path_max_edge_query
    import tpmq_pkg::*;
#(
    parameter int JUMP_LEVELS = 12,
    parameter int WEIGHT_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // node[9:0], other[19:10], weight[51:20]
    input  logic                    s_axis_tuser,  // cmd
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata   // path_max[31:0]
);

    localparam int ROWS          = NODE_COUNT * JUMP_LEVELS;
    localparam int ROW_ADDR_BITS = $clog2(ROWS);
    localparam int LIFT_BITS     = NODE_BITS + WEIGHT_BITS;

    logic                     out_free;
    logic                     res_valid;
    logic [WEIGHT_BITS-1:0]   res_max;
    logic [WEIGHT_BITS-1:0]   in_weight;

    logic                     dep_we;
    logic [NODE_BITS-1:0]     dep_waddr, dep_raddr_a, dep_raddr_b;
    logic [DEPTH_BITS-1:0]    dep_wdata, dep_rdata_a, dep_rdata_b;
    logic                     lift_we;
    logic [ROW_ADDR_BITS-1:0] lift_waddr, lift_raddr_a, lift_raddr_b;
    logic [LIFT_BITS-1:0]     lift_wdata, lift_rdata_a, lift_rdata_b;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    assign in_weight = WEIGHT_BITS'(s_axis_tdata[WEIGHT_LSB +: WEIGHT_IN_BITS]);

    tpmq_ctrl
    #(
        .JUMP_LEVELS (JUMP_LEVELS),
        .WEIGHT_BITS (WEIGHT_BITS)
    )
    u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cmd       (cmd_t'(s_axis_tuser)),
        .in_node      (s_axis_tdata[NODE_LSB +: NODE_BITS]),
        .in_other     (s_axis_tdata[OTHER_LSB +: NODE_BITS]),
        .in_weight    (in_weight),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_max      (res_max),
        .dep_we       (dep_we),
        .dep_waddr    (dep_waddr),
        .dep_wdata    (dep_wdata),
        .dep_raddr_a  (dep_raddr_a),
        .dep_raddr_b  (dep_raddr_b),
        .dep_rdata_a  (dep_rdata_a),
        .dep_rdata_b  (dep_rdata_b),
        .lift_we      (lift_we),
        .lift_waddr   (lift_waddr),
        .lift_wdata   (lift_wdata),
        .lift_raddr_a (lift_raddr_a),
        .lift_raddr_b (lift_raddr_b),
        .lift_rdata_a (lift_rdata_a),
        .lift_rdata_b (lift_rdata_b)
    );

    // depth per node
    tpmq_ram
    #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (NODE_COUNT)
    )
    u_depth_ram
    (
        .clk       (clk),
        .wr_en     (dep_we),
        .wr_addr   (dep_waddr),
        .wr_data   (dep_wdata),
        .rd_addr_a (dep_raddr_a),
        .rd_data_a (dep_rdata_a),
        .rd_addr_b (dep_raddr_b),
        .rd_data_b (dep_rdata_b)
    );

    // one row per node and jump level: {max weight, ancestor}
    tpmq_ram
    #(
        .WIDTH (LIFT_BITS),
        .DEPTH (ROWS)
    )
    u_lift_ram
    (
        .clk       (clk),
        .wr_en     (lift_we),
        .wr_addr   (lift_waddr),
        .wr_data   (lift_wdata),
        .rd_addr_a (lift_raddr_a),
        .rd_data_a (lift_rdata_a),
        .rd_addr_b (lift_raddr_b),
        .rd_data_b (lift_rdata_b)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_axis_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_BITS'(res_max);
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

endmodule

@@ rtl/tpmq_ram.sv @@
// simple dual-read synchronous ram: one write port, two registered read ports
// used for the depth table and the ancestor/max table; no package dependency

module tpmq_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr_a,
    output logic [WIDTH-1:0]     rd_data_a,
    input  logic [ADDR_BITS-1:0] rd_addr_b,
    output logic [WIDTH-1:0]     rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/tpmq_ctrl.sv @@
// sequencer and datapath: fills lifting rows on add, climbs rows on query
// depends on tpmq_pkg; drives the depth ram and the lifting ram

module tpmq_ctrl
    import tpmq_pkg::*;
#(
    parameter int JUMP_LEVELS = 12,
    parameter int WEIGHT_BITS = 32,
    localparam int ROWS          = NODE_COUNT * JUMP_LEVELS,
    localparam int ROW_ADDR_BITS = $clog2(ROWS),
    localparam int LEVEL_BITS    = $clog2(JUMP_LEVELS),
    localparam int LIFT_BITS     = NODE_BITS + WEIGHT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cmd_t                     in_cmd,
    input  logic [NODE_BITS-1:0]     in_node,
    input  logic [NODE_BITS-1:0]     in_other,
    input  logic [WEIGHT_BITS-1:0]   in_weight,
    input  logic                     out_free,
    output logic                     res_valid,
    output logic [WEIGHT_BITS-1:0]   res_max,
    output logic                     dep_we,
    output logic [NODE_BITS-1:0]     dep_waddr,
    output logic [DEPTH_BITS-1:0]    dep_wdata,
    output logic [NODE_BITS-1:0]     dep_raddr_a,
    output logic [NODE_BITS-1:0]     dep_raddr_b,
    input  logic [DEPTH_BITS-1:0]    dep_rdata_a,
    input  logic [DEPTH_BITS-1:0]    dep_rdata_b,
    output logic                     lift_we,
    output logic [ROW_ADDR_BITS-1:0] lift_waddr,
    output logic [LIFT_BITS-1:0]     lift_wdata,
    output logic [ROW_ADDR_BITS-1:0] lift_raddr_a,
    output logic [ROW_ADDR_BITS-1:0] lift_raddr_b,
    input  logic [LIFT_BITS-1:0]     lift_rdata_a,
    input  logic [LIFT_BITS-1:0]     lift_rdata_b
);

    localparam logic [LEVEL_BITS-1:0] K_TOP = LEVEL_BITS'(JUMP_LEVELS - 1);

    state_t state_reg, state_next;

    logic [NODE_BITS-1:0]   x_reg, x_next;
    logic [NODE_BITS-1:0]   y_reg, y_next;
    logic [NODE_BITS-1:0]   up_reg, up_next;
    logic [DEPTH_BITS-1:0]  dx_reg, dx_next;
    logic [DEPTH_BITS-1:0]  dy_reg, dy_next;
    logic [LEVEL_BITS-1:0]  k_reg, k_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [WEIGHT_BITS-1:0] upm_reg, upm_next;
    logic [WEIGHT_BITS-1:0] best_reg, best_next;

    // row fields: ancestor in the low bits, max weight above
    logic [NODE_BITS-1:0]   anc_a, anc_b;
    logic [WEIGHT_BITS-1:0] max_a, max_b;

    logic                   k_last, k_zero;
    logic [LEVEL_BITS-1:0]  k_dec;
    logic                   q_swap;
    logic [NODE_BITS-1:0]   qx, qy;
    logic [DEPTH_BITS-1:0]  qdx, qdy;
    logic                   q1_jump, q1_more;
    logic [NODE_BITS-1:0]   q1_y;
    logic [DEPTH_BITS-1:0]  q1_dy;
    logic                   q2_diff;
    logic [NODE_BITS-1:0]   q2_x, q2_y;
    logic [LEVEL_BITS-1:0]  q2_lvl;

    function automatic logic [ROW_ADDR_BITS-1:0] row_addr(
        input logic [NODE_BITS-1:0]  n,
        input logic [LEVEL_BITS-1:0] k
    );
        return ROW_ADDR_BITS'(n) * ROW_ADDR_BITS'(JUMP_LEVELS) + ROW_ADDR_BITS'(k);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] wmax(
        input logic [WEIGHT_BITS-1:0] a,
        input logic [WEIGHT_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // decisions shared by next-state and datapath logic
    always_comb
    begin
        anc_a   = lift_rdata_a[NODE_BITS-1:0];
        anc_b   = lift_rdata_b[NODE_BITS-1:0];
        max_a   = lift_rdata_a[LIFT_BITS-1:NODE_BITS];
        max_b   = lift_rdata_b[LIFT_BITS-1:NODE_BITS];

        k_last  = (k_reg == K_TOP);
        k_zero  = (k_reg == '0);
        k_dec   = k_reg - LEVEL_BITS'(1);

        // x ends up as the shallower endpoint
        q_swap  = (dep_rdata_a > dep_rdata_b);
        qx      = q_swap ? y_reg : x_reg;
        qy      = q_swap ? x_reg : y_reg;
        qdx     = q_swap ? dep_rdata_b : dep_rdata_a;
        qdy     = q_swap ? dep_rdata_a : dep_rdata_b;

        q1_jump = (dep_rdata_a >= dx_reg);
        q1_y    = q1_jump ? up_reg : y_reg;
        q1_dy   = q1_jump ? dep_rdata_a : dy_reg;
        q1_more = !k_zero && (q1_dy > dx_reg);

        q2_diff = (anc_a != anc_b);
        q2_x    = q2_diff ? anc_a : x_reg;
        q2_y    = q2_diff ? anc_b : y_reg;
        q2_lvl  = k_zero ? '0 : k_dec;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == CMD_QUERY)
                    begin
                        state_next = ST_Q_DEP;
                    end
                    else if (in_node == in_other)
                    begin
                        state_next = ST_A_ROOT;
                    end
                    else
                    begin
                        state_next = ST_A_DEP;
                    end
                end
            end
            ST_A_ROOT:
            begin
                if (k_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_A_DEP:
            begin
                state_next = ST_A_RD;
            end
            ST_A_RD:
            begin
                state_next = ST_A_WR;
            end
            ST_A_WR:
            begin
                state_next = k_last ? ST_IDLE : ST_A_RD;
            end
            ST_Q_DEP:
            begin
                if (dep_rdata_a != dep_rdata_b)
                begin
                    state_next = ST_Q1_ANC;
                end
                else if (x_reg == y_reg)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    state_next = ST_Q2_CHK;
                end
            end
            ST_Q1_ANC:
            begin
                state_next = ST_Q1_DEP;
            end
            ST_Q1_DEP:
            begin
                if (q1_more)
                begin
                    state_next = ST_Q1_ANC;
                end
                else if (x_reg == q1_y)
                begin
                    state_next = ST_Q_OUT;
                end
                else
                begin
                    state_next = ST_Q2_CHK;
                end
            end
            ST_Q2_CHK:
            begin
                if (k_zero)
                begin
                    state_next = ST_Q_FIN;
                end
            end
            ST_Q_FIN:
            begin
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, memory requests and datapath register updates
    always_comb
    begin
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        res_max      = best_reg;
        dep_we       = 1'b0;
        dep_waddr    = x_reg;
        dep_wdata    = DEPTH_ROOT;
        dep_raddr_a  = in_node;
        dep_raddr_b  = in_other;
        lift_we      = 1'b0;
        lift_waddr   = row_addr(x_reg, k_reg);
        lift_wdata   = {best_reg, up_reg};
        lift_raddr_a = row_addr(x_reg, k_reg);
        lift_raddr_b = row_addr(y_reg, k_reg);

        x_next    = x_reg;
        y_next    = y_reg;
        up_next   = up_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        k_next    = k_reg;
        w_next    = w_reg;
        upm_next  = upm_reg;
        best_next = best_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    x_next    = in_node;
                    y_next    = in_other;
                    w_next    = in_weight;
                    best_next = '0;
                    k_next    = '0;
                end
            end
            ST_A_ROOT:
            begin
                dep_we     = 1'b1;
                dep_wdata  = DEPTH_ROOT;
                lift_we    = 1'b1;
                lift_waddr = row_addr(x_reg, k_reg);
                lift_wdata = {{WEIGHT_BITS{1'b0}}, x_reg};
                k_next     = k_reg + LEVEL_BITS'(1);
            end
            ST_A_DEP:
            begin
                // parent depth is on read port b
                dep_we     = 1'b1;
                dep_wdata  = (dep_rdata_b == DEPTH_MAX) ? DEPTH_MAX
                                                        : dep_rdata_b + DEPTH_BITS'(1);
                lift_we    = 1'b1;
                lift_waddr = row_addr(x_reg, '0);
                lift_wdata = {w_reg, y_reg};
                up_next    = y_reg;
                best_next  = w_reg;
                k_next     = LEVEL_BITS'(1);
            end
            ST_A_RD:
            begin
                lift_raddr_a = row_addr(up_reg, k_dec);
            end
            ST_A_WR:
            begin
                lift_we    = 1'b1;
                lift_waddr = row_addr(x_reg, k_reg);
                lift_wdata = {wmax(best_reg, max_a), anc_a};
                up_next    = anc_a;
                best_next  = wmax(best_reg, max_a);
                k_next     = k_reg + LEVEL_BITS'(1);
            end
            ST_Q_DEP:
            begin
                k_next = K_TOP;
                if (dep_rdata_a != dep_rdata_b)
                begin
                    x_next       = qx;
                    y_next       = qy;
                    dx_next      = qdx;
                    dy_next      = qdy;
                    lift_raddr_a = row_addr(qy, K_TOP);
                end
                else
                begin
                    lift_raddr_a = row_addr(x_reg, K_TOP);
                    lift_raddr_b = row_addr(y_reg, K_TOP);
                end
            end
            ST_Q1_ANC:
            begin
                dep_raddr_a = anc_a;
                up_next     = anc_a;
                upm_next    = max_a;
            end
            ST_Q1_DEP:
            begin
                y_next    = q1_y;
                dy_next   = q1_dy;
                best_next = q1_jump ? wmax(best_reg, upm_reg) : best_reg;
                if (q1_more)
                begin
                    k_next       = k_dec;
                    lift_raddr_a = row_addr(q1_y, k_dec);
                end
                else
                begin
                    k_next       = K_TOP;
                    lift_raddr_a = row_addr(x_reg, K_TOP);
                    lift_raddr_b = row_addr(q1_y, K_TOP);
                end
            end
            ST_Q2_CHK:
            begin
                x_next       = q2_x;
                y_next       = q2_y;
                best_next    = q2_diff ? wmax(best_reg, wmax(max_a, max_b)) : best_reg;
                k_next       = q2_lvl;
                lift_raddr_a = row_addr(q2_x, q2_lvl);
                lift_raddr_b = row_addr(q2_y, q2_lvl);
            end
            ST_Q_FIN:
            begin
                best_next = wmax(best_reg, wmax(max_a, max_b));
            end
            ST_Q_OUT:
            begin
                res_valid = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        up_reg   <= up_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        k_reg    <= k_next;
        w_reg    <= w_next;
        upm_reg  <= upm_next;
        best_reg <= best_next;
    end

endmodule

@@ rtl/tpmq_checker.sv @@
// port-level checks for the tree path max-edge query engine
// depends on tpmq_pkg; bound to tree_path_max_edge_query below

module tpmq_checker
    import tpmq_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [S_TDATA_BITS-1:0] s_axis_tdata,
    input logic                    s_axis_tuser,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // every accepted beat leaves the input not ready in the cycle after it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    // a new result only shows up as a query finishes and the engine goes idle
    a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("result beat without a finishing query");

endmodule

bind tree_path_max_edge_query tpmq_checker u_tpmq_checker (.*);
